>>> hw/rtl/pse_pkg.sv
package pse_pkg;

  // Fixed widths of the payload and the stack entries
  localparam int unsigned VAL_W = 48;
  localparam int unsigned ERR_W = 3;

  // ASCII codes the evaluator recognizes
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Saturation limits of Q31.16
  localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;

  // Sticky error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 3'd0,
    ERR_UNDER = 3'd1,
    ERR_OVER  = 3'd2,
    ERR_DIV0  = 3'd3,
    ERR_BADCH = 3'd4,
    ERR_EMPTY = 3'd5
  } err_t;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ERR_W-1:0]        error_code;
  } out_t;

  // Request to the multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } arith_req_t;

  // Response from the multiply/divide unit
  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] value;
  } arith_rsp_t;

  // Saturate a sign and an 80-bit magnitude into Q31.16
  function automatic logic signed [VAL_W-1:0] sat_mag(input logic neg,
                                                      input logic [79:0] mag);
    logic big;
    big = |mag[79:VAL_W-1];
    if (neg) begin
      sat_mag = big ? VAL_MIN : -$signed(mag[VAL_W-1:0]);
    end else begin
      sat_mag = big ? VAL_MAX : $signed(mag[VAL_W-1:0]);
    end
  endfunction

  // Two's complement magnitude of a stack value
  function automatic logic [VAL_W-1:0] abs_val(input logic signed [VAL_W-1:0] v);
    abs_val = v[VAL_W-1] ? (~v + 48'd1) : v;
  endfunction

endpackage

>>> hw/rtl/pse_ram.sv
module pse_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pse_arith.sv
module pse_arith (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pse_pkg::arith_req_t              req,
  input  logic signed [pse_pkg::VAL_W-1:0] op_a,
  input  logic signed [pse_pkg::VAL_W-1:0] op_b,
  output pse_pkg::arith_rsp_t              rsp
);

  typedef enum logic [3:0] {
    AS_IDLE = 4'b0001,
    AS_MUL  = 4'b0010,
    AS_DIV  = 4'b0100,
    AS_SAT  = 4'b1000
  } astate_t;

  astate_t      state_r, state_nxt;
  logic [5:0]   step_r, step_nxt;
  logic         neg_r, neg_nxt;
  logic         is_div_r, is_div_nxt;
  logic [47:0]  xa_r, xa_nxt;
  logic [47:0]  yb_r, yb_nxt;
  logic [95:0]  acc_r, acc_nxt;
  logic [63:0]  quo_r, quo_nxt;
  logic [47:0]  rem_r, rem_nxt;

  logic [23:0]  x_part, y_part;
  logic [47:0]  pp;
  logic [6:0]   shamt;
  logic [48:0]  rem_sh, diff;
  logic [79:0]  mag;

  // One 24x24 partial product per cycle
  assign x_part = step_r[1] ? xa_r[47:24] : xa_r[23:0];
  assign y_part = step_r[0] ? yb_r[47:24] : yb_r[23:0];
  assign pp     = x_part * y_part;
  assign shamt  = 7'(24) * 7'(step_r[1]) + 7'(24) * 7'(step_r[0]);

  // Restoring divide, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[63]};
  assign diff   = rem_sh - {1'b0, yb_r};

  assign mag = is_div_r ? {16'b0, quo_r} : acc_r[95:16];

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    neg_nxt    = neg_r;
    is_div_nxt = is_div_r;
    xa_nxt     = xa_r;
    yb_nxt     = yb_r;
    acc_nxt    = acc_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    unique case (state_r)
      AS_IDLE: begin
        if (req.start) begin
          neg_nxt    = op_a[47] ^ op_b[47];
          is_div_nxt = req.is_div;
          xa_nxt     = pse_pkg::abs_val(op_a);
          yb_nxt     = pse_pkg::abs_val(op_b);
          acc_nxt    = '0;
          quo_nxt    = {pse_pkg::abs_val(op_a), 16'b0};
          rem_nxt    = '0;
          step_nxt   = '0;
          state_nxt  = req.is_div ? AS_DIV : AS_MUL;
        end
      end
      AS_MUL: begin
        acc_nxt  = acc_r + ({48'b0, pp} << shamt);
        step_nxt = step_r + 6'd1;
        if (step_r[1:0] == 2'd3) begin
          state_nxt = AS_SAT;
        end
      end
      AS_DIV: begin
        if (!diff[48]) begin
          rem_nxt = diff[47:0];
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[47:0];
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd63) begin
          state_nxt = AS_SAT;
        end
      end
      AS_SAT: begin
        state_nxt = AS_IDLE;
      end
      default: begin
        state_nxt = AS_IDLE;
      end
    endcase
  end

  // Result is valid for the single cycle in AS_SAT
  assign rsp.done  = (state_r == AS_SAT);
  assign rsp.value = pse_pkg::sat_mag(neg_r, mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    neg_r    <= neg_nxt;
    is_div_r <= is_div_nxt;
    xa_r     <= xa_nxt;
    yb_r     <= yb_nxt;
    acc_r    <= acc_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
  end

endmodule

>>> hw/rtl/prefix_expression_stack_evaluator_top.sv
// Steps: a digit, bad character or underflow completes on acceptance; +, - and divide by
// zero take accept (with stack memory read) and execute; * and / also use the shared unit.
// An item marked last then loads the result register, held back while out_ready stalls.
// Throughput: one item at a time; the next is taken once the item above completes.
// Reset (synchronous, active low) clears the stack count, sticky error, state and
// output valid; the stack memory is not cleared and is only read below the count.
module prefix_expression_stack_evaluator_top #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pse_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pse_pkg::out_t  out_data
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [pse_pkg::ERR_W-1:0]         sticky_r, sticky_nxt;
  logic signed [pse_pkg::VAL_W-1:0]  top_r, top_nxt;
  logic [7:0]                        op_r, op_nxt;
  logic                              last_r, last_nxt;
  logic                              out_valid_r, out_valid_nxt;
  pse_pkg::out_t                     out_data_r, out_data_nxt;

  logic                              in_accept;
  logic                              is_digit, is_op;
  logic [CW-1:0]                     cnt_m1, cnt_m2;
  logic                              ram_we;
  logic [pse_pkg::VAL_W-1:0]         ram_rdata;
  logic signed [pse_pkg::VAL_W-1:0]  o2;
  logic signed [pse_pkg::VAL_W:0]    sum;
  logic                              emit_go;
  logic [pse_pkg::ERR_W-1:0]         end_err;
  pse_pkg::arith_req_t               arith_req;
  pse_pkg::arith_rsp_t               arith_rsp;
  state_t                            done_state;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  // Character decode
  assign is_digit = (in_data.char_code >= pse_pkg::CH_ZERO) &&
                    (in_data.char_code <= pse_pkg::CH_NINE);
  assign is_op    = (in_data.char_code == pse_pkg::CH_ADD) ||
                    (in_data.char_code == pse_pkg::CH_SUB) ||
                    (in_data.char_code == pse_pkg::CH_MUL) ||
                    (in_data.char_code == pse_pkg::CH_DIV);

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);

  // Top of stack lives in top_r; entries below it are in the memory.
  // A push spills the old top to the memory when the stack was not empty.
  assign ram_we = in_accept && is_digit && (count_r < CW'(STACK_DEPTH)) &&
                  (count_r != '0);

  pse_ram #(
    .WIDTH (pse_pkg::VAL_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (top_r),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign o2  = $signed(ram_rdata);
  assign sum = (op_r == pse_pkg::CH_SUB) ? ({top_r[47], top_r} - {o2[47], o2})
                                         : ({top_r[47], top_r} + {o2[47], o2});

  // Multiply and divide by a nonzero divisor go to the iterative unit
  assign arith_req.start  = (state_r == ST_EXEC) &&
                            ((op_r == pse_pkg::CH_MUL) ||
                             ((op_r == pse_pkg::CH_DIV) && (o2 != '0)));
  assign arith_req.is_div = (op_r == pse_pkg::CH_DIV);

  pse_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .op_a  (top_r),
    .op_b  (o2),
    .rsp   (arith_rsp)
  );

  assign done_state = last_r ? ST_EMIT : ST_IDLE;
  assign emit_go    = !out_valid_r || out_ready;
  assign end_err    = ((sticky_r == pse_pkg::ERR_NONE) && (count_r == '0)) ?
                      pse_pkg::ERR_EMPTY : sticky_r;

  // Control sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sticky_nxt    = sticky_r;
    top_nxt       = top_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_data.char_code;
          last_nxt  = in_data.is_last;
          state_nxt = in_data.is_last ? ST_EMIT : ST_IDLE;
          if (is_digit) begin
            if (count_r >= CW'(STACK_DEPTH)) begin
              if (sticky_r == pse_pkg::ERR_NONE) sticky_nxt = pse_pkg::ERR_OVER;
            end else begin
              top_nxt   = {28'b0, in_data.char_code[3:0], 16'b0};
              count_nxt = count_r + CW'(1);
            end
          end else if (!is_op) begin
            if (sticky_r == pse_pkg::ERR_NONE) sticky_nxt = pse_pkg::ERR_BADCH;
          end else if (count_r < CW'(2)) begin
            if (sticky_r == pse_pkg::ERR_NONE) sticky_nxt = pse_pkg::ERR_UNDER;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        case (op_r) inside
          pse_pkg::CH_ADD, pse_pkg::CH_SUB: begin
            if (sum[48] != sum[47]) begin
              top_nxt = sum[48] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
            end else begin
              top_nxt = sum[47:0];
            end
            count_nxt = cnt_m1;
            state_nxt = done_state;
          end
          pse_pkg::CH_DIV: begin
            if (o2 == '0) begin
              if (sticky_r == pse_pkg::ERR_NONE) sticky_nxt = pse_pkg::ERR_DIV0;
              top_nxt   = '0;
              count_nxt = cnt_m1;
              state_nxt = done_state;
            end else begin
              state_nxt = ST_WAIT;
            end
          end
          default: begin
            state_nxt = ST_WAIT;
          end
        endcase
      end
      ST_WAIT: begin
        if (arith_rsp.done) begin
          top_nxt   = arith_rsp.value;
          count_nxt = cnt_m1;
          state_nxt = done_state;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.value      = (count_r == '0) ? '0 : top_r;
          out_data_nxt.error_code = end_err;
          count_nxt               = '0;
          sticky_nxt              = pse_pkg::ERR_NONE;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sticky_r    <= pse_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    op_r       <= op_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stack count never passes the stack depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // The arithmetic unit only finishes while the sequencer waits for it
  a_arith_done: assert property (@(posedge clk) disable iff (!rst_n)
    arith_rsp.done |-> (state_r == ST_WAIT))
    else $error("arith result with no waiting operation");

  // Loading a result clears the expression state
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && emit_go) |=>
      (count_r == '0) && (sticky_r == pse_pkg::ERR_NONE) && out_valid_r)
    else $error("expression state not cleared after result");

endmodule

>>> test/prefix_expression_stack_evaluator_top_test.sv
`timescale 1ns / 100ps

module prefix_expression_stack_evaluator_top_test;
  import pse_pkg::*;

  localparam int DEPTH        = 32;
  localparam int ITEM_TARGET  = 1450;
  localparam int TAIL_CYCLES  = 100;
  localparam int LIMIT_CYCLES = 800000;
  localparam int MAX_PRINTS   = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  prefix_expression_stack_evaluator_top #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Characters waiting to be driven, and results the evaluator still owes us
  in_t  char_q[$];
  out_t pending_results[$];

  // Shadow of the evaluator state
  logic signed [VAL_W-1:0] calc_stack [DEPTH];
  int   calc_depth = 0;
  err_t calc_err   = ERR_NONE;

  int   error_count     = 0;
  int   items_sent      = 0;
  int   items_accepted  = 0;
  int   expressions     = 0;
  int   results_checked = 0;
  int   saturated_seen  = 0;
  int   code_count [8];
  int   cycle_count     = 0;
  int   burst_left      = 0;
  int   gap_left        = 0;
  int   ready_run       = 0;
  out_t want_result;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
             pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Q31.16 arithmetic of the predictor
  // ---------------------------------------------------------------------
  function automatic logic [VAL_W-1:0] magnitude_of(logic signed [VAL_W-1:0] v);
    return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
  endfunction

  // Sign plus wide magnitude, clamped to the Q31.16 range
  function automatic logic signed [VAL_W-1:0] saturate_mag(logic neg, logic [95:0] m);
    if (neg) begin
      if (m >= 96'h8000_0000_0000) return VAL_MIN;
      return ~m[VAL_W-1:0] + 48'd1;
    end
    if (m > 96'h7FFF_FFFF_FFFF) return VAL_MAX;
    return m[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp_sum(logic signed [VAL_W-1:0] a,
                                                        logic signed [VAL_W-1:0] b,
                                                        logic sub);
    logic signed [VAL_W:0] wa;
    logic signed [VAL_W:0] wb;
    logic signed [VAL_W:0] s;
    wa = {a[VAL_W-1], a};
    wb = {b[VAL_W-1], b};
    s  = sub ? (wa - wb) : (wa + wb);
    if (s > VAL_MAX) return VAL_MAX;
    if (s < VAL_MIN) return VAL_MIN;
    return s[VAL_W-1:0];
  endfunction

  // Exact product, shifted down by 16 toward zero
  function automatic logic signed [VAL_W-1:0] fixed_mul(logic signed [VAL_W-1:0] a,
                                                        logic signed [VAL_W-1:0] b);
    logic [95:0] prod;
    prod = {48'd0, magnitude_of(a)} * {48'd0, magnitude_of(b)};
    return saturate_mag(a[VAL_W-1] ^ b[VAL_W-1], prod >> 16);
  endfunction

  // (a << 16) / b toward zero; b is never zero here
  function automatic logic signed [VAL_W-1:0] fixed_div(logic signed [VAL_W-1:0] a,
                                                        logic signed [VAL_W-1:0] b);
    logic [63:0] quo;
    quo = {magnitude_of(a), 16'd0} / {16'd0, magnitude_of(b)};
    return saturate_mag(a[VAL_W-1] ^ b[VAL_W-1], {32'd0, quo});
  endfunction

  // Only the first error of an expression sticks
  function automatic void flag_error(err_t code);
    if (calc_err == ERR_NONE) calc_err = code;
  endfunction

  // Apply one accepted character; on the closing one, queue the result
  function automatic void evaluate_char(in_t item);
    logic signed [VAL_W-1:0] o1;
    logic signed [VAL_W-1:0] o2;
    logic signed [VAL_W-1:0] r;
    logic [7:0] ch;
    out_t res;
    ch = item.char_code;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (calc_depth >= DEPTH) begin
        flag_error(ERR_OVER);
      end else begin
        calc_stack[calc_depth] = {28'd0, 4'(ch - CH_ZERO), 16'd0};
        calc_depth++;
      end
    end else if (ch != CH_ADD && ch != CH_SUB && ch != CH_MUL && ch != CH_DIV) begin
      flag_error(ERR_BADCH);
    end else if (calc_depth < 2) begin
      flag_error(ERR_UNDER);
    end else begin
      o1 = calc_stack[calc_depth - 1];
      o2 = calc_stack[calc_depth - 2];
      calc_depth -= 2;
      case (ch)
        CH_ADD: r = clamp_sum(o1, o2, 1'b0);
        CH_SUB: r = clamp_sum(o1, o2, 1'b1);
        CH_MUL: r = fixed_mul(o1, o2);
        default: begin
          if (o2 == 0) begin
            flag_error(ERR_DIV0);
            r = '0;
          end else begin
            r = fixed_div(o1, o2);
          end
        end
      endcase
      calc_stack[calc_depth] = r;
      calc_depth++;
    end

    if (item.is_last) begin
      if (calc_depth == 0) begin
        flag_error(ERR_EMPTY);
        res.value = '0;
      end else begin
        res.value = calc_stack[calc_depth - 1];
      end
      res.error_code = calc_err;
      pending_results.push_back(res);
      calc_depth = 0;
      calc_err   = ERR_NONE;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: bursts of back-to-back transactions with random gaps
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        evaluate_char(in_data);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_q.size() != 0) begin
          in_data  <= char_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
            gap_left   = $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: alternating ready and stall runs, occasionally long ready stretches
  always @(posedge clk) begin
    if (ready_run > 0) begin
      ready_run--;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_run = $urandom_range(0, 19);
    end else begin
      out_ready <= 1'b1;
      ready_run = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(0, 30);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: value %0d code %0d",
                                  $signed(out_data.value), out_data.error_code));
      end else begin
        want_result = pending_results.pop_front();
        if (out_data.value !== want_result.value) begin
          report_mismatch($sformatf("value %0d, wanted %0d", $signed(out_data.value),
                                    $signed(want_result.value)));
        end
        if (out_data.error_code !== want_result.error_code) begin
          report_mismatch($sformatf("error code %0d, wanted %0d", out_data.error_code,
                                    want_result.error_code));
        end
        results_checked++;
        code_count[want_result.error_code]++;
        if (want_result.value == VAL_MAX || want_result.value == VAL_MIN) saturated_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic last);
    in_t item;
    @(negedge clk);
    while (char_q.size() >= 8) @(negedge clk);
    item.char_code = ch;
    item.is_last   = last;
    char_q.push_back(item);
    items_sent++;
    if (last) expressions++;
  endtask

  // Hold the sender until every owed result is back
  task automatic wait_all_results();
    while (char_q.size() != 0 || in_valid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 3))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  // Any byte half the time, otherwise a legal symbol
  function automatic logic [7:0] random_symbol();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return ($urandom_range(0, 1) == 0) ? random_digit() : random_op();
  endfunction

  // n nines multiplied together; ten or more saturate
  task automatic push_nines(input int n, input logic last);
    repeat (n) send_char(CH_ZERO + 8'd9, 1'b0);
    for (int i = 0; i < n - 1; i++) send_char(CH_MUL, last && (i == n - 2));
  endtask

  // Random expression in stream order (reversed prefix). It may close early or
  // carry random bytes in place of symbols.
  task automatic send_expression(input int n_ops, input int push_pct, input bit early_end,
                                 input int noise_pct);
    int depth;
    int pushes_left;
    int ops_left;
    int stop_at;
    logic [7:0] ch;
    depth       = 0;
    pushes_left = n_ops + 1;
    ops_left    = n_ops;
    stop_at     = early_end ? $urandom_range(1, 2 * n_ops + 1) : 2 * n_ops + 1;
    for (int idx = 1; idx <= stop_at; idx++) begin
      if (pushes_left > 0 && depth < DEPTH &&
          (depth < 2 || ops_left == 0 || $urandom_range(0, 99) < push_pct)) begin
        ch = random_digit();
        pushes_left--;
        depth++;
      end else begin
        ch = random_op();
        ops_left--;
        depth--;
      end
      if ($urandom_range(0, 99) < noise_pct) ch = 8'($urandom_range(0, 255));
      send_char(ch, idx == stop_at);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_basic_cases();
    // subtract to a negative value: 0 - 9
    send_char(CH_ZERO + 8'd9, 1'b0);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_SUB, 1'b1);
    // add
    send_char(CH_ZERO + 8'd4, 1'b0);
    send_char(CH_ZERO + 8'd5, 1'b0);
    send_char(CH_ADD, 1'b1);
    // multiply
    send_char(CH_ZERO + 8'd3, 1'b0);
    send_char(CH_ZERO + 8'd7, 1'b0);
    send_char(CH_MUL, 1'b1);
    // divide with a fractional quotient: 2 / 7
    send_char(CH_ZERO + 8'd7, 1'b0);
    send_char(CH_ZERO + 8'd2, 1'b0);
    send_char(CH_DIV, 1'b1);
    // divide by zero pushes zero
    send_char(CH_ZERO, 1'b0);
    send_char(CH_ZERO + 8'd5, 1'b0);
    send_char(CH_DIV, 1'b1);
    // operator with a single operand
    send_char(CH_ZERO + 8'd8, 1'b0);
    send_char(CH_ADD, 1'b1);
    // top byte value is not a symbol
    send_char(CH_ZERO + 8'd5, 1'b0);
    send_char(8'hFF, 1'b1);
    // operator alone: underflow, then empty at the end
    send_char(CH_MUL, 1'b1);
    // NUL alone: bad character, then empty
    send_char(8'h00, 1'b1);
    // bad character first, then underflow: the first code sticks
    send_char(CH_ZERO + 8'd6, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(CH_DIV, 1'b1);
    // single digit expression
    send_char(CH_ZERO + 8'd9, 1'b1);
    wait_all_results();
  endtask

  task automatic test_stack_limits();
    // one digit more than fits, then fold the stack down
    repeat (DEPTH + 1) send_char(random_digit(), 1'b0);
    for (int i = 0; i < DEPTH - 1; i++) send_char(random_op(), i == DEPTH - 2);
    // exactly full, no overflow
    repeat (DEPTH) send_char(random_digit(), 1'b0);
    for (int i = 0; i < DEPTH - 1; i++) send_char(random_op(), i == DEPTH - 2);
    wait_all_results();
  endtask

  task automatic test_saturation();
    // multiply past the top
    push_nines(10, 1'b1);
    // 0 - big, then minus 9 clamps at the bottom
    send_char(CH_ZERO + 8'd9, 1'b0);
    push_nines(10, 1'b0);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_SUB, 1'b0);
    send_char(CH_SUB, 1'b1);
    // negative big times 9
    send_char(CH_ZERO + 8'd9, 1'b0);
    push_nines(10, 1'b0);
    send_char(CH_ZERO, 1'b0);
    send_char(CH_SUB, 1'b0);
    send_char(CH_MUL, 1'b1);
    // big divided by 1/9
    send_char(CH_ZERO + 8'd9, 1'b0);
    send_char(CH_ZERO + 8'd1, 1'b0);
    send_char(CH_DIV, 1'b0);
    push_nines(10, 1'b0);
    send_char(CH_DIV, 1'b1);
    // big plus big
    push_nines(10, 1'b0);
    push_nines(10, 1'b0);
    send_char(CH_ADD, 1'b1);
    wait_all_results();
  endtask

  task automatic test_random_expressions();
    int kind;
    int n;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // well formed; now and then one that fills the whole stack
        if ($urandom_range(0, 19) == 0) send_expression(DEPTH - 1, 95, 1'b0, 0);
        else send_expression($urandom_range(0, 10), $urandom_range(30, 80), 1'b0, 0);
      end else if (kind < 80) begin
        // closed early, leftovers on the stack
        send_expression($urandom_range(1, 8), $urandom_range(30, 80), 1'b1, 0);
      end else if (kind < 88) begin
        // stray bytes mixed into an expression
        send_expression($urandom_range(1, 8), 50, 1'b0, 15);
      end else if (kind < 96) begin
        // junk sequence
        n = $urandom_range(1, 8);
        for (int i = 1; i <= n; i++) send_char(random_symbol(), i == n);
      end else begin
        // overflow, then a random tail
        n = $urandom_range(DEPTH + 1, DEPTH + 4);
        repeat (n) send_char(random_digit(), 1'b0);
        n = $urandom_range(1, 6);
        for (int i = 1; i <= n; i++) send_char(random_symbol(), i == n);
      end
      if ($urandom_range(0, 29) == 0) wait_all_results();
    end
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_cases();
    test_stack_limits();
    test_saturation();
    test_random_expressions();

    // let anything still in flight surface
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d characters (%0d accepted) as %0d expressions; %0d results checked, %0d saturated.",
             items_sent, items_accepted, expressions, results_checked, saturated_seen);
    $display("Result codes: ok %0d, underflow %0d, overflow %0d, div by zero %0d, bad char %0d, empty %0d",
             code_count[ERR_NONE], code_count[ERR_UNDER], code_count[ERR_OVER],
             code_count[ERR_DIV0], code_count[ERR_BADCH], code_count[ERR_EMPTY]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
